FILE: sv/crc32ws_pkg.sv
`timescale 1ns / 1ps

package crc32ws_pkg;

    localparam int          CRC_WIDTH = 32;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_TOP   = 32'h8000_0000;

    // One column per input bit: the folded image of that single bit
    typedef logic [CRC_WIDTH-1:0][CRC_WIDTH-1:0] crc_matrix_t;

    // Shift a 32-bit value through 32 zero data bits (elaboration only)
    function automatic logic [31:0] crc_shift_word(input logic [31:0] value);
        logic [31:0] acc;
        acc = value;
        for (int k = 0; k < CRC_WIDTH; k++) begin
            if ((acc & CRC_TOP) != 32'h0) begin
                acc = (acc << 1) ^ CRC_POLY;
            end else begin
                acc = acc << 1;
            end
        end
        return acc;
    endfunction

    // Build the fold matrix from unit vectors; the fold is linear in (crc ^ word)
    function automatic crc_matrix_t crc_build_matrix();
        crc_matrix_t m;
        for (int j = 0; j < CRC_WIDTH; j++) begin
            m[j] = crc_shift_word(CRC_TOP >> (CRC_WIDTH - 1 - j));
        end
        return m;
    endfunction

    localparam crc_matrix_t FOLD_MATRIX = crc_build_matrix();

endpackage

FILE: sv/crc32ws_fold.sv
`timescale 1ns / 1ps

module crc32ws_fold
    import crc32ws_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [31:0] data_word,
    output logic [31:0] crc_out
);

    logic [31:0] mixed;

    // Fold the word into the remainder: XOR the matrix columns of all set bits
    always_comb begin
        mixed   = crc_in ^ data_word;
        crc_out = 32'h0;
        for (int j = 0; j < CRC_WIDTH; j++) begin
            if (mixed[j]) begin
                crc_out = crc_out ^ FOLD_MATRIX[j];
            end
        end
    end

endmodule

FILE: sv/crc32_word_stream.sv
`timescale 1ns / 1ps
// A last word is held in the input register, then its CRC in the result register.
// Throughput: one word per cycle unless a last word stalls; the 32-bit XOR fold network
// updates the remainder once per word between the input register and the result register.
// Stall: a last word waits in the input register while the result is held by m_ready low.
// Reset (aresetn low, synchronous): both stages empty, remainder reloaded to all ones.

module crc32_word_stream
    import crc32ws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic        s_is_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc_value
);

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic        in_last_reg;
    logic [31:0] remainder_reg;
    logic [31:0] remainder_next;
    logic        out_valid_reg;
    logic [31:0] out_crc_reg;
    logic        out_free;
    logic        consume;
    logic [31:0] folded;

    // Hold a last word while the result register is still full
    assign out_free = !out_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || consume;

    crc32ws_fold u_fold (
        .crc_in    (remainder_reg),
        .data_word (in_word_reg),
        .crc_out   (folded)
    );

    // Reload all ones after the last word of a message
    always_comb begin
        remainder_next = remainder_reg;
        if (consume) begin
            remainder_next = in_last_reg ? CRC_INIT : folded;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_word_reg <= s_data_word;
            in_last_reg <= s_is_last;
        end
    end

    // Running remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remainder_reg <= CRC_INIT;
        end else begin
            remainder_reg <= remainder_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (consume && in_last_reg) begin
            out_crc_reg <= folded;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_crc_value = out_crc_reg;

endmodule

FILE: dv/crc32_word_stream_tb.sv
`timescale 1ns / 1ps

module crc32_word_stream_tb;
    import crc32ws_pkg::*;

    localparam int WORD_TARGET = 1150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 7;

    // Running CRC of the words accepted so far, plus the CRCs still owed
    class crc_tracker;
        logic [31:0] running_crc;
        logic [31:0] crc_due[$];
        int          errors;

        function new();
            running_crc = CRC_INIT;
            errors      = 0;
        endfunction

        // Fold one word in, most significant bit first
        function logic [31:0] fold_word(logic [31:0] acc, logic [31:0] word);
            logic flip;
            for (int k = 31; k >= 0; k--) begin
                flip = acc[31] ^ word[k];
                acc  = {acc[30:0], 1'b0};
                if (flip) begin
                    acc = acc ^ CRC_POLY;
                end
            end
            return acc;
        endfunction

        // Advance the remainder; on a last word owe its CRC and restart
        function void note_word(logic [31:0] word, logic is_last);
            running_crc = fold_word(running_crc, word);
            if (is_last) begin
                crc_due.push_back(running_crc);
                running_crc = CRC_INIT;
            end
        endfunction

        // Match a delivered CRC against the oldest one owed
        function void check_crc(logic [31:0] actual);
            logic [31:0] want;
            if (crc_due.size() == 0) begin
                $error("crc_value with nothing owed: actual %08h", actual);
                errors++;
                return;
            end
            want = crc_due.pop_front();
            if (actual !== want) begin
                $error("crc_value mismatch: expected %08h, actual %08h", want, actual);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data_word;
    logic        s_is_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_crc_value;

    bit          calm;
    int          cycles;
    int          words_sent;
    crc_tracker  crc_book = new();

    crc32_word_stream u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_word (s_data_word),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Check results before noting words, so a CRC never meets its own word's edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                crc_book.check_crc(m_crc_value);
            end
            if (s_valid && s_ready) begin
                crc_book.note_word(s_data_word, s_is_last);
            end
        end
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one word and hold it until accepted; idle first at random
    task automatic send_word(input logic [31:0] word, input logic is_last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid     <= 1'b0;
            s_data_word <= $urandom;
            s_is_last   <= 1'($urandom_range(1));
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_word <= word;
        s_is_last   <= is_last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Mostly random words, with some all-zero, all-one, one-hot and one-cold words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(31);
            3:       return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_word(pick_word(), i == len - 1);
        end
    endtask

    initial begin
        int len;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_word <= '0;
        s_is_last   <= 1'b0;
        m_ready     <= 1'b0;
        calm        <= 1'b0;
        cycles      <= 0;
        words_sent  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-word messages: field extremes and alternating bit patterns
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h5555_5555, 1'b1);
        // Multi-word messages: remainder must carry across words
        send_word(32'h3132_3334, 1'b0);
        send_word(32'h3536_3738, 1'b0);
        send_word(32'h3900_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hDEAD_BEEF, 1'b1);

        // Random messages, mostly short, some long; a middle stretch with no idling
        while (words_sent < WORD_TARGET) begin
            calm <= (words_sent >= 300 && words_sent < 500);
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            send_message(len);
        end
        s_valid <= 1'b0;
        calm    <= 1'b0;

        // Drain owed CRCs, then watch for strays
        while (crc_book.crc_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (crc_book.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/crc32ws_pkg.sv
sv/crc32ws_fold.sv
sv/crc32_word_stream.sv
dv/crc32_word_stream_tb.sv
